// File: rtl/core/gnaf_pkg.sv
// Shared types, constants and helpers for the glob name and attribute filter.
// No dependencies; gnaf_cell, gnaf_out_buf and the top level refer to this package.
package gnaf_pkg;

	// Pattern positions held by the matcher row
	localparam int PATTERN_MAX = 16;
	// Pattern characters that the two pattern registers hold
	localparam int PAT_REG_CHARS = 16;
	localparam int LEN_W = $clog2(PATTERN_MAX + 1);
	localparam int CMP_W = (LEN_W > 5) ? LEN_W : 5;

	localparam logic [7:0] STAR_CHAR   = 8'h2A;
	localparam logic [7:0] QMARK_CHAR  = 8'h3F;
	localparam logic [7:0] UPPER_A     = 8'h41;
	localparam logic [7:0] UPPER_Z     = 8'h5A;
	localparam logic [7:0] CASE_OFFSET = 8'd32;

	typedef enum logic [2:0] {
		CFG_PAT_LOW    = 3'd0,
		CFG_PAT_HIGH   = 3'd1,
		CFG_PAT_LEN    = 3'd2,
		CFG_NAME_CHECK = 3'd3,
		CFG_IGN_CASE   = 3'd4,
		CFG_TYPE_MODE  = 3'd5,
		CFG_SIZE_MODE  = 3'd6,
		CFG_SIZE_LIMIT = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		TYPE_ANY  = 2'd0,
		TYPE_FILE = 2'd1,
		TYPE_DIR  = 2'd2,
		TYPE_RSVD = 2'd3
	} type_mode_t;

	typedef enum logic [1:0] {
		SIZE_NONE = 2'd0,
		SIZE_EQ   = 2'd1,
		SIZE_GT   = 2'd2,
		SIZE_LT   = 2'd3
	} size_mode_t;

	// Signals handed from one matcher cell to the next
	typedef struct packed {
		logic a_carry; // star closure over the current positions
		logic shift;   // this position consumed the character
		logic n_carry; // star closure over the next positions
	} link_t;

	// One verdict word
	typedef struct packed {
		logic selected;
		logic name_matched;
	} result_t;

	// ASCII upper to lower case fold when case is ignored
	function automatic logic [7:0] fold(input logic [7:0] c, input logic ign);
		logic [7:0] r;
		r = c;
		if (ign && c >= UPPER_A && c <= UPPER_Z) begin
			r = c + CASE_OFFSET;
		end
		return r;
	endfunction

endpackage

// File: rtl/core/gnaf_in_if.sv
// Input channel of the filter: one name byte per word plus entry attributes.
// Depends on nothing.
interface gnaf_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  name_char;
	logic        last_char;
	logic        is_directory;
	logic [31:0] file_size;

	modport source (output valid, name_char, last_char, is_directory, file_size,
		input ready);
	modport sink (input valid, name_char, last_char, is_directory, file_size,
		output ready);
endinterface

// File: rtl/core/gnaf_out_if.sv
// Output channel of the filter: one verdict word per entry.
// Depends on nothing.
interface gnaf_out_if;
	logic valid;
	logic ready;
	logic selected;
	logic name_matched;

	modport source (output valid, selected, name_matched, input ready);
	modport sink (input valid, selected, name_matched, output ready);
endinterface

// File: rtl/core/gnaf_cell.sv
// One matcher cell: holds the active bit of one pattern position and passes
// closure and shift signals to its right neighbor. Uses gnaf_pkg.
module gnaf_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              restart,
	input  logic              home,
	input  logic [7:0]        pat_char,
	input  logic              in_use,
	input  logic [7:0]        name_c,
	input  logic              ignore_case,
	input  gnaf_pkg::link_t   link_in,
	output gnaf_pkg::link_t   link_out,
	output logic              a_bit,
	output logic              n_bit
);

	logic a_q;
	logic a_eff;
	logic a_cl;
	logic star;
	logic hit;
	logic self_keep;
	logic n_cl;

	// Stored bit is kept relative to the home value, so reset gives the start state
	assign a_eff = a_q ^ home;

	// Current positions after star closure, then this position's transition
	assign star      = (pat_char == gnaf_pkg::STAR_CHAR);
	assign hit       = (pat_char == gnaf_pkg::QMARK_CHAR) ||
		(gnaf_pkg::fold(pat_char, ignore_case) == name_c);
	assign a_cl      = a_eff | link_in.a_carry;
	assign self_keep = in_use & a_cl & star;
	assign n_cl      = self_keep | link_in.shift | link_in.n_carry;

	assign link_out.a_carry = self_keep;
	assign link_out.shift   = in_use & a_cl & ~star & hit;
	assign link_out.n_carry = in_use & n_cl & star;

	assign a_bit = a_eff;
	assign n_bit = n_cl;

	// Active bit update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= 1'b0;
		end else if (step) begin
			a_q <= (restart ? home : n_cl) ^ home;
		end
	end

endmodule

// File: rtl/core/gnaf_out_buf.sv
// Two-word verdict buffer between the matcher row and the output channel.
// Uses gnaf_pkg and gnaf_out_if.
module gnaf_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  gnaf_pkg::result_t  push_word,
	output logic               full,
	gnaf_out_if.source         out_ch
);

	gnaf_pkg::result_t mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop                 = out_ch.valid & out_ch.ready;
	assign full                = (cnt_q == 2'd2);
	assign out_ch.valid        = (cnt_q != 2'd0);
	assign out_ch.selected     = mem_q[rd_q].selected;
	assign out_ch.name_matched = mem_q[rd_q].name_matched;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Payload storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_word;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("verdict pushed into a full buffer");
`endif

endmodule

// File: rtl/core/glob_name_and_attribute_filter_top.sv
// Top level of the glob name and attribute filter: configuration registers,
// matcher cell row, verdict logic. Uses gnaf_pkg, gnaf_in_if, gnaf_out_if,
// gnaf_cell and gnaf_out_buf.
//
//  channel   dir   word                                        per entry
//  in_ch     in    name_char, last_char, is_directory, size    one word per byte
//  out_ch    out   selected, name_matched                      one word
//  cfg       in    cfg_we, cfg_index, cfg_data                 no handshake
//
// One name byte is taken every cycle unless the output buffer is full; all pattern
// positions update in the same cycle through the star closure chain that runs
// along the cell row. The verdict is written into the output buffer when the last
// byte is taken. A two-word output buffer lets bytes keep flowing while a verdict
// waits; in_ch.ready drops only when two verdicts are pending.
// Reset puts the matcher at the start position and clears all but the buffer payload.
module glob_name_and_attribute_filter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	gnaf_in_if.sink     in_ch,
	gnaf_out_if.source  out_ch
);

	localparam int PM = gnaf_pkg::PATTERN_MAX;

	logic [63:0] pat_low_q;
	logic [63:0] pat_high_q;
	logic [4:0]  pat_len_q;
	logic        name_check_q;
	logic        ign_case_q;
	logic [1:0]  type_mode_q;
	logic [1:0]  size_mode_q;
	logic [31:0] size_limit_q;

	logic                     accept;
	logic                     restart;
	logic                     full;
	logic [gnaf_pkg::LEN_W-1:0] eff_len;
	logic [7:0]               name_c;
	gnaf_pkg::link_t          links [PM+1];
	logic [PM-1:0]            a_vec;
	logic [PM:0]              n_vec;
	logic                     name_ok;
	logic                     type_ok;
	logic                     size_ok;
	gnaf_pkg::result_t        verdict;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q    <= '0;
			pat_high_q   <= '0;
			pat_len_q    <= '0;
			name_check_q <= 1'b0;
			ign_case_q   <= 1'b0;
			type_mode_q  <= '0;
			size_mode_q  <= '0;
			size_limit_q <= '0;
		end else if (cfg_we) begin
			case (gnaf_pkg::cfg_reg_t'(cfg_index))
				gnaf_pkg::CFG_PAT_LOW:    pat_low_q    <= cfg_data;
				gnaf_pkg::CFG_PAT_HIGH:   pat_high_q   <= cfg_data;
				gnaf_pkg::CFG_PAT_LEN:    pat_len_q    <= cfg_data[4:0];
				gnaf_pkg::CFG_NAME_CHECK: name_check_q <= cfg_data[0];
				gnaf_pkg::CFG_IGN_CASE:   ign_case_q   <= cfg_data[0];
				gnaf_pkg::CFG_TYPE_MODE:  type_mode_q  <= cfg_data[1:0];
				gnaf_pkg::CFG_SIZE_MODE:  size_mode_q  <= cfg_data[1:0];
				gnaf_pkg::CFG_SIZE_LIMIT: size_limit_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// Handshake
	assign in_ch.ready = ~full;
	assign accept      = in_ch.valid & in_ch.ready;
	assign restart     = in_ch.last_char;

	// Lengths beyond the row count as the full row
	assign eff_len = (gnaf_pkg::CMP_W'(pat_len_q) > gnaf_pkg::CMP_W'(PM)) ?
		gnaf_pkg::LEN_W'(PM) : gnaf_pkg::LEN_W'(pat_len_q);

	assign name_c   = gnaf_pkg::fold(in_ch.name_char, ign_case_q);
	assign links[0] = '0;

	// Matcher cell row
	for (genvar i = 0; i < PM; i++) begin : g_cell
		logic [7:0] pch;
		if (i < 8) begin : g_lo
			assign pch = pat_low_q[8*i +: 8];
		end else if (i < gnaf_pkg::PAT_REG_CHARS) begin : g_hi
			assign pch = pat_high_q[8*(i-8) +: 8];
		end else begin : g_none
			assign pch = 8'h00;
		end

		gnaf_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.step        (accept),
			.restart     (restart),
			.home        ((i == 0) ? 1'b1 : 1'b0),
			.pat_char    (pch),
			.in_use      (gnaf_pkg::LEN_W'(i) < eff_len),
			.name_c      (name_c),
			.ignore_case (ign_case_q),
			.link_in     (links[i]),
			.link_out    (links[i+1]),
			.a_bit       (a_vec[i]),
			.n_bit       (n_vec[i])
		);
	end

	// End position only collects what the last cell hands over
	assign n_vec[PM] = links[PM].shift | links[PM].n_carry;

	// Verdict
	assign name_ok = name_check_q ? n_vec[eff_len] : 1'b1;

	always_comb begin
		case (gnaf_pkg::type_mode_t'(type_mode_q))
			gnaf_pkg::TYPE_FILE: type_ok = ~in_ch.is_directory;
			gnaf_pkg::TYPE_DIR:  type_ok = in_ch.is_directory;
			default:             type_ok = 1'b1;
		endcase
	end

	always_comb begin
		size_ok = 1'b1;
		if (size_limit_q != 32'd0) begin
			case (gnaf_pkg::size_mode_t'(size_mode_q))
				gnaf_pkg::SIZE_EQ: size_ok = (in_ch.file_size == size_limit_q);
				gnaf_pkg::SIZE_GT: size_ok = (in_ch.file_size > size_limit_q);
				gnaf_pkg::SIZE_LT: size_ok = (in_ch.file_size < size_limit_q);
				default:           size_ok = 1'b1;
			endcase
		end
	end

	assign verdict.selected     = name_ok & type_ok & size_ok;
	assign verdict.name_matched = name_ok;

	gnaf_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept & restart),
		.push_word (verdict),
		.full      (full),
		.out_ch    (out_ch)
	);

`ifndef NO_ASSERTIONS
	a_restart_state: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && restart) |=> (a_vec == PM'(1)))
		else $error("matcher not back at start position after last byte");

	a_verdict_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> $past(accept && restart))
		else $error("verdict appeared without a last byte");

	a_sel_implies_name: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (!out_ch.selected || out_ch.name_matched))
		else $error("entry selected although its name did not match");
`endif

endmodule

// File: tb/gnaf_tb_pkg.sv
// Verification package for the glob name and attribute filter: a verdict predictor
// and scoreboard class that mirrors the matcher row, registers and verdict logic.
// Depends on gnaf_pkg.
package gnaf_tb_pkg;
	import gnaf_pkg::*;

	typedef logic [PATTERN_MAX:0] pos_vec_t;

	class filter_scoreboard;
		// Register copies, in step with what the block holds
		logic [63:0] pat_lo;
		logic [63:0] pat_hi;
		logic [4:0]  pat_len;
		logic        name_on;
		logic        fold_on;
		type_mode_t  tmode;
		size_mode_t  smode;
		logic [31:0] lim;
		// Active pattern positions between name bytes
		pos_vec_t    live;
		result_t     verdicts[$];
		int          errors;

		function new();
			pat_lo  = '0;
			pat_hi  = '0;
			pat_len = '0;
			name_on = 1'b0;
			fold_on = 1'b0;
			tmode   = TYPE_ANY;
			smode   = SIZE_NONE;
			lim     = '0;
			live    = pos_vec_t'(1);
			errors  = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [63:0] d);
			case (idx)
				CFG_PAT_LOW:    pat_lo  = d;
				CFG_PAT_HIGH:   pat_hi  = d;
				CFG_PAT_LEN:    pat_len = d[4:0];
				CFG_NAME_CHECK: name_on = d[0];
				CFG_IGN_CASE:   fold_on = d[0];
				CFG_TYPE_MODE:  tmode   = type_mode_t'(d[1:0]);
				CFG_SIZE_MODE:  smode   = size_mode_t'(d[1:0]);
				CFG_SIZE_LIMIT: lim     = d[31:0];
				default: ;
			endcase
		endfunction

		// Pattern character at a position; nothing is held past the two registers
		function logic [7:0] pat_at(int i);
			if (i < 8) return pat_lo[8*i +: 8];
			if (i < 16) return pat_hi[8*(i-8) +: 8];
			return 8'h00;
		endfunction

		function logic [7:0] lower(logic [7:0] c);
			if (fold_on && c >= UPPER_A && c <= UPPER_Z) return c + CASE_OFFSET;
			return c;
		endfunction

		function int used_len();
			return (pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
		endfunction

		// A star lets its position run on to the next one, chaining along the row
		function pos_vec_t star_close(pos_vec_t v, int n);
			for (int i = 0; i < n; i++) begin
				if (v[i] && pat_at(i) == STAR_CHAR) v[i+1] = 1'b1;
			end
			return v;
		endfunction

		// One accepted input word: advance the matcher, queue a verdict on the last byte
		function void note_input(logic [7:0] ch, logic last, logic dir, logic [31:0] sz);
			logic [7:0] c;
			logic [7:0] p;
			int         n;
			pos_vec_t   nxt;
			result_t    r;
			c    = lower(ch);
			n    = used_len();
			live = star_close(live, n);
			nxt  = '0;
			for (int i = 0; i < n; i++) begin
				if (live[i]) begin
					p = pat_at(i);
					if (p == STAR_CHAR) nxt[i] = 1'b1;
					else if (p == QMARK_CHAR || lower(p) == c) nxt[i+1] = 1'b1;
				end
			end
			nxt = star_close(nxt, n);
			if (!last) begin
				live = nxt;
				return;
			end
			r.name_matched = name_on ? nxt[n] : 1'b1;
			r.selected     = r.name_matched;
			if (tmode == TYPE_FILE && dir) r.selected = 1'b0;
			if (tmode == TYPE_DIR && !dir) r.selected = 1'b0;
			if (lim != 0) begin
				if (smode == SIZE_EQ && sz != lim) r.selected = 1'b0;
				if (smode == SIZE_GT && sz <= lim) r.selected = 1'b0;
				if (smode == SIZE_LT && sz >= lim) r.selected = 1'b0;
			end
			verdicts.push_back(r);
			live = pos_vec_t'(1);
		endfunction

		// One accepted verdict word against the oldest prediction
		function void check_verdict(logic sel, logic nm);
			result_t e;
			if (verdicts.size() == 0) begin
				$display("%0t: verdict with none pending: selected %0b name_matched %0b",
					$time, sel, nm);
				errors++;
				return;
			end
			e = verdicts.pop_front();
			if (sel !== e.selected) begin
				$display("%0t: selected mismatch, expected %0b, got %0b",
					$time, e.selected, sel);
				errors++;
			end
			if (nm !== e.name_matched) begin
				$display("%0t: name_matched mismatch, expected %0b, got %0b",
					$time, e.name_matched, nm);
				errors++;
			end
		endfunction

		function int pending();
			return verdicts.size();
		endfunction
	endclass

endpackage

// File: tb/tb_top.sv
// Top-level testbench of the glob name and attribute filter: directed entries for
// the corner cases, then random settings and names with random idling on both sides.
// Depends on gnaf_pkg, gnaf_tb_pkg, the channel interfaces and the filter RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import gnaf_pkg::*;
	import gnaf_tb_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 4;
	localparam int RANDOM_BYTES = 500;

	typedef struct {
		logic [63:0] lo;
		logic [63:0] hi;
		logic [4:0]  len;
		logic        name_on;
		logic        fold_on;
		type_mode_t  tm;
		size_mode_t  sm;
		logic [31:0] lim;
	} filter_setting_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	gnaf_in_if  in_ch();
	gnaf_out_if out_ch();

	glob_name_and_attribute_filter_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	filter_scoreboard sb = new();
	filter_setting_t  cur;
	logic [7:0]       name_bytes[$];
	bit               in_steady;
	bit               out_steady;
	int               bytes_sent;
	int               cycle_count;

	// Clock and reset
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
	end

	// Run limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Monitor: words accepted on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
				sb.check_verdict(out_ch.selected, out_ch.name_matched);
			if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
				sb.note_input(in_ch.name_char, in_ch.last_char, in_ch.is_directory,
					in_ch.file_size);
		end
	end

	// Verdict sink: random stall before each word
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = out_steady ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (out_ch.valid !== 1'b1);
			@(negedge clk);
		end
	end

	// Send one name byte; called and returns at a falling edge, valid left high
	task automatic drive_byte(input logic [7:0] ch, input logic last, input logic dir,
		input logic [31:0] sz);
		int gap;
		gap = in_steady ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.name_char    <= ch;
		in_ch.last_char    <= last;
		in_ch.is_directory <= dir;
		in_ch.file_size    <= sz;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		@(negedge clk);
		bytes_sent++;
	endtask

	// Whole entry from name_bytes; attributes matter only on the last byte
	task automatic send_entry(input logic dir, input logic [31:0] sz);
		int n;
		n = name_bytes.size();
		for (int i = 0; i < n; i++) begin
			if (i == n - 1) drive_byte(name_bytes[i], 1'b1, dir, sz);
			else drive_byte(name_bytes[i], 1'b0, 1'($urandom_range(0, 1)), $urandom);
		end
	endtask

	// Stop sending and let every pending verdict drain out of the block
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(input cfg_reg_t idx, input logic [63:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		sb.write_reg(idx, d);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apply_setting();
		cfg_write(CFG_PAT_LOW, cur.lo);
		cfg_write(CFG_PAT_HIGH, cur.hi);
		cfg_write(CFG_PAT_LEN, 64'(cur.len));
		cfg_write(CFG_NAME_CHECK, 64'(cur.name_on));
		cfg_write(CFG_IGN_CASE, 64'(cur.fold_on));
		cfg_write(CFG_TYPE_MODE, 64'(cur.tm));
		cfg_write(CFG_SIZE_MODE, 64'(cur.sm));
		cfg_write(CFG_SIZE_LIMIT, 64'(cur.lim));
	endtask

	function automatic logic [7:0] letter_ab();
		logic [7:0] c;
		c = $urandom_range(0, 1) ? "b" : "a";
		return $urandom_range(0, 1) ? (c ^ 8'h20) : c;
	endfunction

	function automatic logic [7:0] gen_pat_char();
		int r;
		r = $urandom_range(0, 19);
		if (r < 5) return STAR_CHAR;
		if (r < 8) return QMARK_CHAR;
		if (r < 16) return letter_ab();
		if (r == 16) return 8'h00;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] gen_name_char();
		case ($urandom_range(0, 4))
			0, 1: return letter_ab();
			2: return $urandom_range(0, 1) ? STAR_CHAR : QMARK_CHAR;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] pat_char_of(int i);
		return (i < 8) ? cur.lo[8*i +: 8] : cur.hi[8*(i-8) +: 8];
	endfunction

	// Name that follows the current pattern, sometimes broken, sometimes pure noise
	task automatic build_name();
		int         n;
		logic [7:0] p;
		name_bytes.delete();
		n = (cur.len > PATTERN_MAX) ? PATTERN_MAX : int'(cur.len);
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 12)) name_bytes.push_back(gen_name_char());
		end else begin
			for (int i = 0; i < n; i++) begin
				p = pat_char_of(i);
				if (p == STAR_CHAR) begin
					repeat ($urandom_range(0, 3)) name_bytes.push_back(gen_name_char());
				end else if (p == QMARK_CHAR) begin
					name_bytes.push_back(8'($urandom_range(0, 255)));
				end else if (cur.fold_on && $urandom_range(0, 1) &&
					((p >= "A" && p <= "Z") || (p >= "a" && p <= "z"))) begin
					name_bytes.push_back(p ^ 8'h20);
				end else begin
					name_bytes.push_back(p);
				end
			end
			if ($urandom_range(0, 4) == 0) begin
				if (name_bytes.size() > 0 && $urandom_range(0, 1))
					name_bytes[$urandom_range(0, name_bytes.size() - 1)] =
						8'($urandom_range(0, 255));
				else
					name_bytes.push_back(gen_name_char());
			end
		end
		if (name_bytes.size() == 0) name_bytes.push_back(gen_name_char());
	endtask

	function automatic logic [31:0] gen_size();
		case ($urandom_range(0, 5))
			0: return cur.lim;
			1: return cur.lim + 1;
			2: return cur.lim - 1;
			3: return 32'h0;
			4: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// New random setting for phase k; some phases land on the extremes
	task automatic pick_setting(input int k);
		for (int i = 0; i < 8; i++) begin
			cur.lo[8*i +: 8] = gen_pat_char();
			cur.hi[8*i +: 8] = gen_pat_char();
		end
		if (k % 13 == 5) begin
			cur.lo = '1;
			cur.hi = '1;
		end
		if (k % 7 == 0) cur.len = 5'd16;
		else if (k % 7 == 1) cur.len = 5'd0;
		else if (k % 11 == 2) cur.len = 5'($urandom_range(17, 31));
		else cur.len = 5'($urandom_range(1, 16));
		cur.name_on = ($urandom_range(0, 9) != 0);
		cur.fold_on = 1'($urandom_range(0, 1));
		cur.tm      = type_mode_t'($urandom_range(0, 3));
		cur.sm      = size_mode_t'($urandom_range(0, 3));
		case ($urandom_range(0, 4))
			0: cur.lim = 32'h0;
			1: cur.lim = 32'hFFFF_FFFF;
			2: cur.lim = 32'($urandom_range(1, 16));
			default: cur.lim = $urandom;
		endcase
	endtask

	// Directed entries: corner cases of the name, type and size checks
	task automatic directed_entries();
		// Registers still at reset: name check off, every entry selected
		name_bytes = '{8'h78};
		send_entry(1'b0, 32'h0);
		settle();

		// Lone star, unused type mode, zero size limit with equal compare
		cur.lo = 64'h2A; cur.hi = 64'h0; cur.len = 5'd1;
		cur.name_on = 1'b1; cur.fold_on = 1'b0;
		cur.tm = TYPE_RSVD; cur.sm = SIZE_EQ; cur.lim = 32'h0;
		apply_setting();
		name_bytes = '{8'hFF};
		send_entry(1'b1, 32'hFFFF_FFFF);
		settle();

		// Over-long length, zero byte in the pattern, trailing stars, case folding
		cur.lo = 64'h2A2A2A2A_2A003F41; cur.hi = 64'h2A2A2A2A_2A2A2A2A;
		cur.len = 5'd31; cur.fold_on = 1'b1;
		cur.tm = TYPE_FILE; cur.sm = SIZE_GT; cur.lim = 32'd5;
		apply_setting();
		name_bytes = '{8'h61, 8'h80, 8'h00};
		send_entry(1'b0, 32'd6);
		name_bytes = '{8'h41, 8'h7F, 8'h00, 8'h7A, 8'h7A};
		send_entry(1'b1, 32'hFFFF_FFFF);
		settle();

		// Case folding off: lower-case name misses an upper-case pattern
		cur.fold_on = 1'b0; cur.tm = TYPE_DIR; cur.sm = SIZE_LT;
		apply_setting();
		name_bytes = '{8'h61, 8'h00, 8'h00};
		send_entry(1'b1, 32'd4);
		settle();

		// Length change between two bytes of one name
		cur.len = 5'd1;
		cfg_write(CFG_PAT_LEN, 64'(cur.len));
		drive_byte(8'h41, 1'b0, 1'b0, 32'h0);
		settle();
		cur.len = 5'd2;
		cfg_write(CFG_PAT_LEN, 64'(cur.len));
		drive_byte(8'h5A, 1'b1, 1'b1, 32'd4);
		settle();

		// Name check off, size equal at the top of the range
		cur.name_on = 1'b0; cur.tm = TYPE_ANY; cur.sm = SIZE_EQ; cur.lim = 32'hFFFF_FFFF;
		apply_setting();
		name_bytes = '{8'h00};
		send_entry(1'b0, 32'hFFFF_FFFF);
		name_bytes = '{8'hFF};
		send_entry(1'b1, 32'h0);
		settle();

		// Empty pattern never matches a name
		cur.name_on = 1'b1; cur.len = 5'd0;
		apply_setting();
		name_bytes = '{8'h2A};
		send_entry(1'b0, 32'd1);
		settle();
	endtask

	// Stimulus
	initial begin
		int phase;
		cfg_we             = 1'b0;
		cfg_index          = CFG_PAT_LOW;
		cfg_data           = '0;
		in_ch.valid        = 1'b0;
		in_ch.name_char    = '0;
		in_ch.last_char    = 1'b0;
		in_ch.is_directory = 1'b0;
		in_ch.file_size    = '0;
		in_steady          = 1'b0;
		out_steady         = 1'b0;
		bytes_sent         = 0;
		@(posedge arst_n);
		@(negedge clk);

		directed_entries();

		phase = 0;
		bytes_sent = 0;
		while (bytes_sent < RANDOM_BYTES) begin
			pick_setting(phase);
			apply_setting();
			in_steady  = ($urandom_range(0, 3) == 0);
			out_steady = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(3, 10)) begin
				build_name();
				send_entry(1'($urandom_range(0, 1)), gen_size());
			end
			settle();
			phase++;
		end

		settle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
